// ===== rtl/mp2d_pkg.sv =====
`timescale 1ns / 1ps

package mp2d_pkg;

   // Geometry limits
   localparam int MAX_WINDOW   = 4;
   localparam int LINE_DEPTH   = 256;
   localparam int MAX_HEIGHT   = 256;
   localparam int MAX_CHANNELS = 1024;

   // Field and register widths
   localparam int PIX_W      = 8;
   localparam int WIN_W      = 3;
   localparam int DIM_W      = 9;
   localparam int CH_W       = 11;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // Reciprocal used to test stride alignment without a divider
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = DIM_W + RECIP_W;
   localparam int BACK_W      = DIM_W + WIN_W;

   // Register reset values
   localparam logic [WIN_W-1:0] RST_WINDOW_SIZE   = 3'd2;
   localparam logic [WIN_W-1:0] RST_STEP_SIZE     = 3'd2;
   localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 9'd128;
   localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 9'd128;
   localparam logic [CH_W-1:0]  RST_CHANNEL_COUNT = 11'd32;

   typedef logic [PIX_W-1:0] pixel_type;

   // One column of the window: entry i is the pixel i rows above the newest row
   typedef pixel_type [MAX_WINDOW-1:0] column_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SIZE   = 3'd0,
      CSR_STEP_SIZE     = 3'd1,
      CSR_IMAGE_WIDTH   = 3'd2,
      CSR_IMAGE_HEIGHT  = 3'd3,
      CSR_CHANNEL_COUNT = 3'd4
   } csr_index_type;

   // Control shared by every cell of the column chain
   typedef struct packed {
      logic             shift;
      logic [WIN_W-1:0] rows;
   } cell_ctrl_type;

   // ceil(2^RECIP_SHIFT / s): floor(x * recip >> RECIP_SHIFT) == floor(x / s) for x < 512
   function automatic logic [RECIP_W-1:0] step_recip(input logic [WIN_W-1:0] s);
      logic [RECIP_W-1:0] r;
      begin
         case (s)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21846;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13108;
            3'd6:    r = 17'd10923;
            3'd7:    r = 17'd9363;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== rtl/mp2d_ifs.sv =====
`timescale 1ns / 1ps

// Pixel input channel
interface mp2d_req_if;
   logic                        valid;
   logic                        ready;
   logic [mp2d_pkg::PIX_W-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// Pooled result channel
interface mp2d_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mp2d_pkg::PIX_W-1:0]  pooled_max;
   logic                        row_done;
   logic                        channel_done;
   logic                        tensor_done;

   modport source (output valid, output pooled_max, output row_done,
                   output channel_done, output tensor_done, input ready);
   modport sink   (input valid, input pooled_max, input row_done,
                   input channel_done, input tensor_done, output ready);
endinterface

// Register write channel
interface mp2d_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mp2d_pkg::CSR_IDX_W-1:0]   index;
   logic [mp2d_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/max_pool_2d_stream.sv =====
`timescale 1ns / 1ps

// Streaming 2-D max pooling. Pixels enter in channel, row, column raster order, one per
// cycle unless rsp stalls; a window's result appears on rsp after its bottom-right pixel
// is taken. The rate is set by the line store: four 256-byte row banks, each read once
// per pixel at the current column with only the current row's bank written, and a chain
// of four column cells that advances one step per pixel. Partial windows at the right and
// bottom edges give no result; out-of-range settings or a window larger than the image
// give no result while the raster position keeps advancing. Registers may be written
// only while no pixel is in flight and take effect for the next pixel. The line store
// needs no clearing after reset: a window reads only rows written in the current channel.
module max_pool_2d_stream (
   input  logic        clock,
   input  logic        reset,
   mp2d_req_if.sink    req_if,
   mp2d_rsp_if.source  rsp_if,
   mp2d_csr_if.sink    csr_if
);

   localparam int NW = mp2d_pkg::MAX_WINDOW;

   // ---------------------------------------------------------------- registers
   logic [mp2d_pkg::WIN_W-1:0] window_size_ff,   window_size_in;
   logic [mp2d_pkg::WIN_W-1:0] step_size_ff,     step_size_in;
   logic [mp2d_pkg::DIM_W-1:0] image_width_ff,   image_width_in;
   logic [mp2d_pkg::DIM_W-1:0] image_height_ff,  image_height_in;
   logic [mp2d_pkg::CH_W-1:0]  channel_count_ff, channel_count_in;

   assign csr_if.ready = 1'b1;

   // Decode a register transfer
   always_comb begin
      window_size_in   = window_size_ff;
      step_size_in     = step_size_ff;
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      channel_count_in = channel_count_ff;
      if (csr_if.valid) begin
         unique case (mp2d_pkg::csr_index_type'(csr_if.index))
            mp2d_pkg::CSR_WINDOW_SIZE:   window_size_in   = csr_if.data[mp2d_pkg::WIN_W-1:0];
            mp2d_pkg::CSR_STEP_SIZE:     step_size_in     = csr_if.data[mp2d_pkg::WIN_W-1:0];
            mp2d_pkg::CSR_IMAGE_WIDTH:   image_width_in   = csr_if.data[mp2d_pkg::DIM_W-1:0];
            mp2d_pkg::CSR_IMAGE_HEIGHT:  image_height_in  = csr_if.data[mp2d_pkg::DIM_W-1:0];
            mp2d_pkg::CSR_CHANNEL_COUNT: channel_count_in = csr_if.data[mp2d_pkg::CH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= mp2d_pkg::RST_WINDOW_SIZE;
         step_size_ff     <= mp2d_pkg::RST_STEP_SIZE;
         image_width_ff   <= mp2d_pkg::RST_IMAGE_WIDTH;
         image_height_ff  <= mp2d_pkg::RST_IMAGE_HEIGHT;
         channel_count_ff <= mp2d_pkg::RST_CHANNEL_COUNT;
      end else begin
         window_size_ff   <= window_size_in;
         step_size_ff     <= step_size_in;
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         channel_count_ff <= channel_count_in;
      end
   end

   // ---------------------------------------------------------------- pipeline control
   logic req_accept;
   logic s1_valid_ff, s1_valid_in, s1_adv, s1_emit;
   logic s2_valid_ff, s2_valid_in, s2_adv;
   logic s2_emit_ff;
   logic s3_valid_ff, s3_valid_in, s3_load;

   assign s3_load     = s2_adv && s2_emit_ff;
   assign s2_adv      = s2_valid_ff && (!s2_emit_ff || !s3_valid_ff || rsp_if.ready);
   assign s1_adv      = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign req_accept  = req_if.valid && req_if.ready;

   assign s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
   assign s3_valid_in = s3_load ? 1'b1 : (rsp_if.ready ? 1'b0 : s3_valid_ff);

   // ---------------------------------------------------------------- raster position
   logic [mp2d_pkg::DIM_W-1:0] col_ff, col_in;
   logic [mp2d_pkg::DIM_W-1:0] row_ff, row_in;
   logic [mp2d_pkg::CH_W-1:0]  chan_ff, chan_in;
   logic [mp2d_pkg::DIM_W:0]   col_inc, row_inc;
   logic [mp2d_pkg::CH_W:0]    chan_inc;

   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign row_inc  = {1'b0, row_ff} + 1'b1;
   assign chan_inc = {1'b0, chan_ff} + 1'b1;

   // Advance column, wrap into row and channel against the raw limits
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      chan_in = chan_ff;
      if (req_accept) begin
         col_in = col_inc[mp2d_pkg::DIM_W-1:0];
         if (col_inc >= {1'b0, image_width_ff}) begin
            col_in = '0;
            row_in = row_inc[mp2d_pkg::DIM_W-1:0];
            if (row_inc >= {1'b0, image_height_ff}) begin
               row_in  = '0;
               chan_in = chan_inc[mp2d_pkg::CH_W-1:0];
               if (chan_inc >= {1'b0, channel_count_ff}) begin
                  chan_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         chan_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         chan_ff <= chan_in;
      end
   end

   // ---------------------------------------------------------------- settings check
   logic cfg_ok;

   assign cfg_ok = (window_size_ff != '0)
                && (window_size_ff <= mp2d_pkg::WIN_W'(NW))
                && (step_size_ff != '0)
                && (image_width_ff != '0)
                && (image_width_ff <= mp2d_pkg::DIM_W'(mp2d_pkg::LINE_DEPTH))
                && (image_height_ff != '0)
                && (image_height_ff <= mp2d_pkg::DIM_W'(mp2d_pkg::MAX_HEIGHT))
                && (channel_count_ff != '0)
                && (channel_count_ff <= mp2d_pkg::CH_W'(mp2d_pkg::MAX_CHANNELS))
                && (mp2d_pkg::DIM_W'(window_size_ff) <= image_width_ff)
                && (mp2d_pkg::DIM_W'(window_size_ff) <= image_height_ff);

   // ---------------------------------------------------------------- window alignment
   logic [mp2d_pkg::DIM_W:0]    col_off_w, row_off_w, col_reach, row_reach;
   logic [mp2d_pkg::RECIP_W-1:0] recip;
   logic [mp2d_pkg::PROD_W-1:0]  col_prod, row_prod;
   logic col_ge, row_ge, last_col, last_row, last_chan;

   assign col_ge    = col_inc >= (mp2d_pkg::DIM_W+1)'(window_size_ff);
   assign row_ge    = row_inc >= (mp2d_pkg::DIM_W+1)'(window_size_ff);
   assign col_off_w = col_inc - (mp2d_pkg::DIM_W+1)'(window_size_ff);
   assign row_off_w = row_inc - (mp2d_pkg::DIM_W+1)'(window_size_ff);

   // The next window along would end past the edge
   assign col_reach = {1'b0, col_ff} + (mp2d_pkg::DIM_W+1)'(step_size_ff);
   assign row_reach = {1'b0, row_ff} + (mp2d_pkg::DIM_W+1)'(step_size_ff);
   assign last_col  = col_reach >= {1'b0, image_width_ff};
   assign last_row  = row_reach >= {1'b0, image_height_ff};
   assign last_chan = chan_inc == {1'b0, channel_count_ff};

   // Quotient by the stride through its reciprocal
   assign recip    = mp2d_pkg::step_recip(step_size_ff);
   assign col_prod = mp2d_pkg::PROD_W'(col_off_w[mp2d_pkg::DIM_W-1:0])
                   * mp2d_pkg::PROD_W'(recip);
   assign row_prod = mp2d_pkg::PROD_W'(row_off_w[mp2d_pkg::DIM_W-1:0])
                   * mp2d_pkg::PROD_W'(recip);

   // ---------------------------------------------------------------- line store banks
   logic [NW-1:0]            bank_wr;
   mp2d_pkg::pixel_type      bank_q [NW];

   for (genvar b = 0; b < NW; b++) begin : g_bank
      assign bank_wr[b] = req_accept && cfg_ok
                       && (row_ff[mp2d_pkg::SLOT_W-1:0] == mp2d_pkg::SLOT_W'(b));

      mp2d_ram #(
         .WIDTH (mp2d_pkg::PIX_W),
         .DEPTH (mp2d_pkg::LINE_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_wr[b]),
         .wr_addr (col_ff[mp2d_pkg::ADDR_W-1:0]),
         .wr_data (req_if.pixel),
         .rd_en   (req_accept),
         .rd_addr (col_ff[mp2d_pkg::ADDR_W-1:0]),
         .rd_data (bank_q[b])
      );
   end

   // ---------------------------------------------------------------- stage 1
   mp2d_pkg::pixel_type           s1_pixel_ff;
   logic [mp2d_pkg::SLOT_W-1:0]   s1_slot_ff;
   logic                          s1_live_ff;
   logic [mp2d_pkg::WIN_W-1:0]    s1_ws_ff, s1_step_ff;
   logic                          s1_col_ge_ff, s1_row_ge_ff;
   logic [mp2d_pkg::DIM_W-1:0]    s1_col_off_ff, s1_row_off_ff;
   logic [mp2d_pkg::DIM_W-1:0]    s1_col_quo_ff, s1_row_quo_ff;
   logic                          s1_last_col_ff, s1_last_row_ff, s1_last_chan_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff     <= req_if.pixel;
         s1_slot_ff      <= row_ff[mp2d_pkg::SLOT_W-1:0];
         s1_live_ff      <= cfg_ok;
         s1_ws_ff        <= window_size_ff;
         s1_step_ff      <= step_size_ff;
         s1_col_ge_ff    <= col_ge;
         s1_row_ge_ff    <= row_ge;
         s1_col_off_ff   <= col_off_w[mp2d_pkg::DIM_W-1:0];
         s1_row_off_ff   <= row_off_w[mp2d_pkg::DIM_W-1:0];
         s1_col_quo_ff   <= col_prod[mp2d_pkg::RECIP_SHIFT +: mp2d_pkg::DIM_W];
         s1_row_quo_ff   <= row_prod[mp2d_pkg::RECIP_SHIFT +: mp2d_pkg::DIM_W];
         s1_last_col_ff  <= last_col;
         s1_last_row_ff  <= last_row;
         s1_last_chan_ff <= last_chan;
      end
   end

   // Window origin sits on the stride grid when quotient times stride gives back the offset
   logic [mp2d_pkg::BACK_W-1:0] col_back, row_back;
   logic                        col_hit, row_hit;

   assign col_back = mp2d_pkg::BACK_W'(s1_col_quo_ff) * mp2d_pkg::BACK_W'(s1_step_ff);
   assign row_back = mp2d_pkg::BACK_W'(s1_row_quo_ff) * mp2d_pkg::BACK_W'(s1_step_ff);
   assign col_hit  = s1_col_ge_ff && (col_back == mp2d_pkg::BACK_W'(s1_col_off_ff));
   assign row_hit  = s1_row_ge_ff && (row_back == mp2d_pkg::BACK_W'(s1_row_off_ff));
   assign s1_emit  = s1_live_ff && col_hit && row_hit;

   // Assemble this column as the store holds it after the pixel
   mp2d_pkg::column_type s1_column;

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         s1_column[i] = bank_q[s1_slot_ff - mp2d_pkg::SLOT_W'(i)];
      end
      if (s1_live_ff) begin
         s1_column[0] = s1_pixel_ff;
      end
   end

   // ---------------------------------------------------------------- stage 2: column chain
   logic [mp2d_pkg::WIN_W-1:0] s2_ws_ff;
   logic s2_row_done_ff, s2_chan_done_ff, s2_tens_done_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_emit_ff      <= s1_emit;
         s2_ws_ff        <= s1_ws_ff;
         s2_row_done_ff  <= s1_last_col_ff;
         s2_chan_done_ff <= s1_last_col_ff && s1_last_row_ff;
         s2_tens_done_ff <= s1_last_col_ff && s1_last_row_ff && s1_last_chan_ff;
      end
   end

   mp2d_pkg::cell_ctrl_type cell_ctrl;
   mp2d_pkg::column_type    cell_col [NW];
   mp2d_pkg::pixel_type     cell_max [NW];

   assign cell_ctrl.shift = s1_adv;
   assign cell_ctrl.rows  = s2_ws_ff;

   for (genvar k = 0; k < NW; k++) begin : g_cell
      if (k == 0) begin : g_head
         mp2d_cell u_cell (
            .clock   (clock),
            .ctrl    (cell_ctrl),
            .col_in  (s1_column),
            .col_out (cell_col[k]),
            .col_max (cell_max[k])
         );
      end else begin : g_tail
         mp2d_cell u_cell (
            .clock   (clock),
            .ctrl    (cell_ctrl),
            .col_in  (cell_col[k-1]),
            .col_out (cell_col[k]),
            .col_max (cell_max[k])
         );
      end
   end

   // Combine the newest columns of the window
   mp2d_pkg::pixel_type window_max;

   always_comb begin
      mp2d_pkg::pixel_type best;
      best = '0;
      for (int k = 0; k < NW; k++) begin
         if ((mp2d_pkg::WIN_W'(k) < s2_ws_ff) && (cell_max[k] > best)) begin
            best = cell_max[k];
         end
      end
      window_max = best;
   end

   // ---------------------------------------------------------------- stage 3: output register
   mp2d_pkg::pixel_type pooled_max_ff;
   logic row_done_ff, channel_done_ff, tensor_done_ff;

   always_ff @(posedge clock) begin
      if (s3_load) begin
         pooled_max_ff   <= window_max;
         row_done_ff     <= s2_row_done_ff;
         channel_done_ff <= s2_chan_done_ff;
         tensor_done_ff  <= s2_tens_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   assign rsp_if.valid        = s3_valid_ff;
   assign rsp_if.pooled_max   = pooled_max_ff;
   assign rsp_if.row_done     = row_done_ff;
   assign rsp_if.channel_done = channel_done_ff;
   assign rsp_if.tensor_done  = tensor_done_ff;

   // ---------------------------------------------------------------- assertions
   a_done_nesting: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.tensor_done |-> rsp_if.channel_done && rsp_if.row_done)
      else $error("tensor end flagged without row and channel end");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> s1_valid_ff)
      else $error("accepted pixel lost before stage 1");

   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_wr))
      else $error("more than one line store bank written");

   a_result_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !s3_load)
      else $error("pending result overwritten");

endmodule

// ===== rtl/mp2d_ram.sv =====
`timescale 1ns / 1ps

module mp2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read at a written address sees old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mp2d_cell.sv =====
`timescale 1ns / 1ps

module mp2d_cell (
   input  logic                    clock,
   input  mp2d_pkg::cell_ctrl_type ctrl,
   input  mp2d_pkg::column_type    col_in,
   output mp2d_pkg::column_type    col_out,
   output mp2d_pkg::pixel_type     col_max
);

   mp2d_pkg::column_type col_ff;

   // Take the neighbor's column whenever the chain advances
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

   // Maximum over the rows that belong to the window
   always_comb begin
      mp2d_pkg::pixel_type best;
      best = '0;
      for (int i = 0; i < mp2d_pkg::MAX_WINDOW; i++) begin
         if ((mp2d_pkg::WIN_W'(i) < ctrl.rows) && (col_ff[i] > best)) begin
            best = col_ff[i];
         end
      end
      col_max = best;
   end

endmodule
